>>> rtl/cbl_pkg.sv
package cbl_pkg;

    // Session modes
    typedef enum logic [1:0] {
        MODE_WAIT   = 2'd0,
        MODE_ACTIVE = 2'd1,
        MODE_DONE   = 2'd2
    } cbl_mode_t;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        KIND_ACK   = 3'd0,
        KIND_ERASE = 3'd1,
        KIND_WRITE = 3'd2,
        KIND_BOOT  = 3'd3,
        KIND_NAK   = 3'd4
    } cbl_kind_t;

    // Opcodes in identifier bits 19..16
    localparam logic [3:0] OP_ACK    = 4'd0;
    localparam logic [3:0] OP_ERASE  = 4'd1;
    localparam logic [3:0] OP_WRITE  = 4'd2;
    localparam logic [3:0] OP_FINISH = 4'd3;

    localparam logic REPLY_ACK = 1'b0;
    localparam logic REPLY_NAK = 1'b1;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_ERASE = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_BOOT  = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_HEADER_VALUE = 3'd0;
    localparam logic [2:0] REG_ENTER_ID     = 3'd1;
    localparam logic [2:0] REG_ERASE_TAG    = 3'd2;
    localparam logic [2:0] REG_WRITE_LIMIT  = 3'd3;
    localparam logic [2:0] REG_APP_BASE     = 3'd4;

    localparam int MAX_LEN = 8;

    // Shift for the reciprocal multiply that divides a 16-bit offset by the
    // flash word size (at most 8, so 16 + 3 bits keeps the quotient exact).
    localparam int RECIP_SHIFT = 19;

    typedef struct packed {
        logic [8:0]  header_value;
        logic [28:0] enter_id;
        logic [15:0] erase_tag;
        logic [15:0] write_limit;
        logic [31:0] app_base;
    } cbl_cfg_t;

    typedef struct packed {
        cbl_kind_t   kind;
        logic [15:0] offset;
        logic [15:0] offset_quot;
        logic [3:0]  len;
        logic [63:0] payload;
        logic        busy;
    } cbl_cmd_t;

endpackage

>>> rtl/cbl_front.sv
module cbl_front
    import cbl_pkg::*;
#(
    parameter int FLASH_WORD_BYTES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cbl_cfg_t    cfg,
    input  logic        in_valid,
    input  logic        queue_full,
    input  logic        rx_ok,
    input  logic        ext_id,
    input  logic [28:0] frame_id,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_payload,
    output logic        push,
    output cbl_cmd_t    cmd
);

    localparam int WORD    = (FLASH_WORD_BYTES < 1) ? 1 : FLASH_WORD_BYTES;
    localparam int RECIP   = ((1 << RECIP_SHIFT) + WORD - 1) / WORD;
    localparam int RECIP_W = RECIP_SHIFT + 1;

    cbl_mode_t mode_reg;
    cbl_mode_t mode_next;

    logic                    accept;
    logic [3:0]              opcode;
    logic [15:0]             embedded;
    logic [RECIP_W+15:0]     recip_prod;

    assign accept   = in_valid & ~queue_full;
    assign opcode   = frame_id[19:16];
    assign embedded = frame_id[15:0];

    // offset / word via reciprocal multiply
    assign recip_prod = (RECIP_W + 16)'(embedded) * (RECIP_W + 16)'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_WAIT;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        push            = 1'b0;
        cmd.kind        = KIND_ACK;
        cmd.offset      = embedded;
        cmd.offset_quot = recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
        cmd.len         = frame_len;
        cmd.payload     = frame_payload;
        if (accept && rx_ok && ext_id)
        begin
            case (mode_reg)
                MODE_WAIT:
                begin
                    if (frame_len == 4'd0 && frame_id == cfg.enter_id)
                    begin
                        mode_next = MODE_ACTIVE;
                        push      = 1'b1;
                        cmd.kind  = KIND_ACK;
                    end
                end
                MODE_ACTIVE:
                begin
                    if (frame_id[28:20] == cfg.header_value)
                    begin
                        push = 1'b1;
                        case (opcode)
                            OP_ACK:   cmd.kind = KIND_ACK;
                            OP_ERASE: cmd.kind = (embedded == cfg.erase_tag) ?
                                                 KIND_ERASE : KIND_NAK;
                            OP_WRITE: cmd.kind = KIND_WRITE;
                            OP_FINISH:
                            begin
                                cmd.kind  = KIND_BOOT;
                                mode_next = MODE_DONE;
                            end
                            default:  cmd.kind = KIND_NAK;
                        endcase
                    end
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        cmd.busy = (mode_next == MODE_ACTIVE);
    end

endmodule

>>> rtl/cbl_fifo.sv
module cbl_fifo
    import cbl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  cbl_cmd_t push_cmd,
    input  logic     pop,
    output logic     full,
    output logic     not_empty,
    output cbl_cmd_t head
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    cbl_cmd_t               mem [DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W:0]         count_reg;
    logic [PTR_W:0]         count_next;

    assign full      = (count_reg == (PTR_W + 1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/cbl_back.sv
module cbl_back
    import cbl_pkg::*;
#(
    parameter int FLASH_WORD_BYTES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cbl_cfg_t    cfg,
    input  logic        cmd_valid,
    input  cbl_cmd_t    cmd,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        reply,
    output logic [1:0]  action,
    output logic [31:0] write_address,
    output logic [3:0]  write_length,
    output logic [63:0] write_data,
    output logic        busy_res
);

    localparam int WORD = (FLASH_WORD_BYTES < 1) ? 1 : FLASH_WORD_BYTES;

    logic        out_valid_reg;
    logic        reply_reg,   reply_next;
    logic [1:0]  action_reg,  action_next;
    logic [31:0] addr_reg,    addr_next;
    logic [3:0]  len_reg,     len_next;
    logic [63:0] data_reg,    data_next;
    logic        busy_reg;

    logic [18:0] quot_back;
    logic        offset_aligned;
    logic        len_aligned;
    logic        write_ok;
    logic [63:0] masked_data;

    assign pop = cmd_valid & (~out_valid_reg | ~out_stall);

    // quotient times word equals offset exactly when offset is aligned
    assign quot_back      = 19'(cmd.offset_quot) * 19'(WORD);
    assign offset_aligned = (quot_back == 19'(cmd.offset));

    always_comb
    begin
        len_aligned = 1'b0;
        for (int k = 0; k <= MAX_LEN; k++)
        begin
            if (7'(k * WORD) == 7'(cmd.len))
            begin
                len_aligned = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int b = 0; b < MAX_LEN; b++)
        begin
            masked_data[b*8 +: 8] = (4'(b) < cmd.len) ? cmd.payload[b*8 +: 8] : 8'd0;
        end
    end

    assign write_ok = (cmd.len <= 4'(MAX_LEN)) & offset_aligned & len_aligned
                      & (cmd.offset < cfg.write_limit);

    always_comb
    begin
        reply_next  = REPLY_ACK;
        action_next = ACT_NONE;
        addr_next   = '0;
        len_next    = '0;
        data_next   = '0;
        case (cmd.kind)
            KIND_ACK:   action_next = ACT_NONE;
            KIND_ERASE: action_next = ACT_ERASE;
            KIND_BOOT:  action_next = ACT_BOOT;
            KIND_WRITE:
            begin
                if (write_ok)
                begin
                    action_next = ACT_WRITE;
                    addr_next   = cfg.app_base + 32'(cmd.offset);
                    len_next    = cmd.len;
                    data_next   = masked_data;
                end
                else
                begin
                    reply_next = REPLY_NAK;
                end
            end
            default:    reply_next = REPLY_NAK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            reply_reg  <= reply_next;
            action_reg <= action_next;
            addr_reg   <= addr_next;
            len_reg    <= len_next;
            data_reg   <= data_next;
            busy_reg   <= cmd.busy;
        end
    end

    assign out_valid     = out_valid_reg;
    assign reply         = reply_reg;
    assign action        = action_reg;
    assign write_address = addr_reg;
    assign write_length  = len_reg;
    assign write_data    = data_reg;
    assign busy_res      = busy_reg;

endmodule

>>> rtl/can_bootloader_command_decoder.sv
// Channel  Direction  Handshake             Payload
// -------  ---------  --------------------  ---------------------------------------------
// in       receive    in_valid / in_stall   rx_ok, ext_id, frame_id, frame_len, frame_payload
// out      send       out_valid / out_stall reply, action, write_address, write_length,
//                                           write_data, busy_res
// cfg      write      cfg_we                cfg_index, cfg_data
//
// One frame transfer per cycle is taken while the two-entry command queue has room.
// A frame that yields a reply is written into the command queue and waits at the queue
// head until the output register can take it, then loads the output register; the reply
// transfer completes once out_stall is low.
// in_stall is high only while the queue is full; the queue fills only when out_stall
// holds the output register.
// Reset (rst_n, async, active low) returns the session to waiting, empties the queue
// and the output register, and loads the register defaults.
module can_bootloader_command_decoder
    import cbl_pkg::*;
#(
    parameter int FLASH_WORD_BYTES = 2
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        rx_ok,
    input  logic        ext_id,
    input  logic [28:0] frame_id,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_payload,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        reply,
    output logic [1:0]  action,
    output logic [31:0] write_address,
    output logic [3:0]  write_length,
    output logic [63:0] write_data,
    output logic        busy_res
);

    cbl_cfg_t cfg_reg;

    logic     push;
    logic     pop;
    logic     queue_full;
    logic     queue_not_empty;
    cbl_cmd_t front_cmd;
    cbl_cmd_t head_cmd;

    // Configuration registers; writes must only happen while idle, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_value <= 9'd239;
            cfg_reg.enter_id     <= 29'd250609664;
            cfg_reg.erase_tag    <= 16'd23130;
            cfg_reg.write_limit  <= 16'd26624;
            cfg_reg.app_base     <= 32'd134217728;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HEADER_VALUE: cfg_reg.header_value <= cfg_data[8:0];
                REG_ENTER_ID:     cfg_reg.enter_id     <= cfg_data[28:0];
                REG_ERASE_TAG:    cfg_reg.erase_tag    <= cfg_data[15:0];
                REG_WRITE_LIMIT:  cfg_reg.write_limit  <= cfg_data[15:0];
                REG_APP_BASE:     cfg_reg.app_base     <= cfg_data;
                default:          cfg_reg.app_base     <= cfg_reg.app_base;
            endcase
        end
    end

    assign in_stall = queue_full;

    // Front: session tracking and opcode classification
    cbl_front #(
        .FLASH_WORD_BYTES (FLASH_WORD_BYTES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .queue_full    (queue_full),
        .rx_ok         (rx_ok),
        .ext_id        (ext_id),
        .frame_id      (frame_id),
        .frame_len     (frame_len),
        .frame_payload (frame_payload),
        .push          (push),
        .cmd           (front_cmd)
    );

    // Command queue decoupling classification from result formatting
    cbl_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_cmd)
    );

    // Back: write checks, address add, data masking, output register
    cbl_back #(
        .FLASH_WORD_BYTES (FLASH_WORD_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd_valid     (queue_not_empty),
        .cmd           (head_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply         (reply),
        .action        (action),
        .write_address (write_address),
        .write_length  (write_length),
        .write_data    (write_data),
        .busy_res      (busy_res)
    );

endmodule
